// ===== hw/rtl/latched_serial_driver_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Latched serial driver sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LATCHED_SERIAL_DRIVER_SEQUENCER_TOP_MACROS_SVH
`define LATCHED_SERIAL_DRIVER_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define LSDS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lsds_pkg.sv =====
// ----------------------------------------------------------------------------
// Latched serial driver sequencer package
// Word types of both channels, operation codes and the fault reset table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsds_pkg;

	// operation codes, equal to the command codes that start them
	typedef enum logic [1:0] {
		OP_IDLE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RESET = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// command word
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] write_byte;
		logic       fault_in;
	} cmd_word_t;

	// result word
	typedef struct packed {
		logic        clock_out;
		logic        latch_out;
		logic        data_out;
		logic        enable_out;
		logic        busy_res;
		logic        rejected;
		logic        fault_valid;
		logic [15:0] fault_word;
	} res_word_t;

	// fault reset sequence: bit 0 clock, bit 1 latch, one entry per tick
	localparam int RESET_LEN   = 28;
	localparam int RESET_IDX_W = 5;

	localparam logic [1:0] RESET_SEQ [RESET_LEN] = '{
		2'd2, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0,
		2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0,
		2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0,
		2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0
	};

endpackage

`default_nettype wire

// ===== hw/rtl/latched_serial_driver_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Latched serial driver sequencer
// Data path: an accepted word waits in the input register, then steps into
// the result register when it is free. Throughput: one word per cycle unless
// res_stall holds the result register; sequencer state updates in one pass.
// Reset: all sequencer state, pin levels and the enable register clear at
// once on arst_n; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "latched_serial_driver_sequencer_top_macros.svh"

module latched_serial_driver_sequencer_top
	import lsds_pkg::*;
#(
	parameter int OUT_BITS   = 8,
	parameter int FAULT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	cmd_word_t cmd_s1;
	logic      vld_s1;
	res_word_t res_q;
	logic      res_vld_q;
	logic      enable_q;
	logic      advance;
	res_word_t seq_res;

	// a word moves on when the result register is free or being emptied
	assign advance   = vld_s1 && (!res_vld_q || !res_stall);
	assign cmd_stall = vld_s1 && res_vld_q && res_stall;
	assign cfg_ready = 1'b1;

	// enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd_word;
		end
	end

	// sequencer
	lsds_seq #(
		.OUT_BITS   (OUT_BITS),
		.FAULT_BITS (FAULT_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cmd    (cmd_s1),
		.enable (enable_q),
		.res    (seq_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= advance || (res_vld_q && res_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= seq_res;
		end
	end

	assign res_valid = res_vld_q;
	assign res_word  = res_q;

	// checks
	`LSDS_ASSERT_NEXT(a_s1_hold, vld_s1 && !advance, vld_s1 && $stable(cmd_s1), "word lost")
	`LSDS_ASSERT_IMPL(a_fault_busy, res_vld_q && res_q.fault_valid, res_q.busy_res, "fault idle")
	`LSDS_ASSERT_IMPL(a_rej_busy, res_vld_q && res_q.rejected, res_q.busy_res, "reject idle")
	`LSDS_ASSERT_IMPL(a_word_zero, res_vld_q && !res_q.fault_valid, res_q.fault_word == 16'd0,
		"stray word")

endmodule

`default_nettype wire

// ===== hw/rtl/lsds_seq.sv =====
// ----------------------------------------------------------------------------
// Latched serial driver sequencer core
// Holds the running operation, step count, shift and fault registers and the
// pin levels; works out one tick of pin levels per fired command word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsds_seq
	import lsds_pkg::*;
#(
	parameter int OUT_BITS   = 8,
	parameter int FAULT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  cmd_word_t cmd,
	input  logic      enable,
	output res_word_t res
);

	localparam int WRITE_LEN = 2 * OUT_BITS + 2;
	localparam int READ_LEN  = 2 * FAULT_BITS + 6;
	localparam int MAX_LEN   = (WRITE_LEN > READ_LEN) ?
		((WRITE_LEN > RESET_LEN) ? WRITE_LEN : RESET_LEN) :
		((READ_LEN > RESET_LEN) ? READ_LEN : RESET_LEN);
	localparam int STEP_W    = $clog2(MAX_LEN + 1);

	op_t                   op_q, op_d;
	logic [STEP_W-1:0]     step_q, step_d;
	logic [OUT_BITS-1:0]   shift_q, shift_d;
	logic [FAULT_BITS-1:0] acc_q, acc_d;
	logic                  clk_q, lat_q, dout_q;
	logic                  clk_d, lat_d, dout_d;

	// state registers, advanced once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_IDLE;
			step_q <= '0;
			shift_q <= '0;
			acc_q  <= '0;
			clk_q  <= 1'b0;
			lat_q  <= 1'b0;
			dout_q <= 1'b0;
		end else if (fire) begin
			op_q   <= op_d;
			step_q <= step_d;
			shift_q <= shift_d;
			acc_q  <= acc_d;
			clk_q  <= clk_d;
			lat_q  <= lat_d;
			dout_q <= dout_d;
		end
	end

	// one tick: start or reject, pin levels for the step, end of sequence
	always_comb begin
		logic                  start;
		op_t                   op_cur;
		logic [STEP_W-1:0]     s;
		logic [STEP_W-1:0]     s_next;
		logic [STEP_W-1:0]     len;
		logic [RESET_IDX_W-1:0] ridx;
		logic [1:0]            rent;

		start  = (op_q == OP_IDLE) && (cmd.command != 2'd0);
		op_cur = start ? op_t'(cmd.command) : op_q;
		s      = start ? '0 : step_q;
		s_next = s + STEP_W'(1);

		shift_d = (start && op_t'(cmd.command) == OP_WRITE) ?
			OUT_BITS'(cmd.write_byte) : shift_q;
		acc_d   = (start && op_t'(cmd.command) == OP_READ) ? '0 : acc_q;
		clk_d   = clk_q;
		lat_d   = lat_q;
		dout_d  = dout_q;
		op_d    = op_cur;
		step_d  = step_q;

		ridx = (s < STEP_W'(RESET_LEN)) ? s[RESET_IDX_W-1:0] :
			RESET_IDX_W'(RESET_LEN - 1);
		rent = RESET_SEQ[ridx];

		unique case (op_cur)
			OP_WRITE: len = STEP_W'(WRITE_LEN);
			OP_RESET: len = STEP_W'(RESET_LEN);
			default:  len = STEP_W'(READ_LEN);
		endcase

		res             = '0;
		res.enable_out  = enable;
		res.rejected    = (op_q != OP_IDLE) && (cmd.command != 2'd0);
		res.busy_res    = (op_cur != OP_IDLE);

		unique case (op_cur)
			OP_WRITE: begin
				// latch high with clock, then bit pairs MSB first
				if (s == '0) begin
					lat_d = 1'b1;
					clk_d = 1'b1;
				end else if (s[0] && s <= STEP_W'(2 * OUT_BITS - 1)) begin
					lat_d   = 1'b0;
					clk_d   = 1'b0;
					dout_d  = shift_d[OUT_BITS-1];
					shift_d = shift_d << 1;
				end else if (!s[0] && s <= STEP_W'(2 * OUT_BITS)) begin
					clk_d = 1'b1;
				end
			end
			OP_RESET: begin
				clk_d = rent[0];
				lat_d = rent[1];
			end
			OP_READ: begin
				// latch pulse, then clock pairs with a sample on each rise but the first
				if (s == STEP_W'(0)) begin
					clk_d = 1'b0;
				end else if (s == STEP_W'(1)) begin
					dout_d = 1'b0;
				end else if (s == STEP_W'(2)) begin
					lat_d = 1'b1;
				end else if (s == STEP_W'(3)) begin
					lat_d = 1'b0;
				end else if (s == STEP_W'(4)) begin
					lat_d = 1'b1;
				end else if (s <= STEP_W'(4 + 2 * FAULT_BITS)) begin
					clk_d = s[0];
				end
				if (s >= STEP_W'(7) && s[0] && s <= STEP_W'(2 * FAULT_BITS + 3)) begin
					acc_d = {acc_d[FAULT_BITS-2:0], cmd.fault_in};
				end
			end
			default: begin
			end
		endcase

		res.clock_out = clk_d;
		res.latch_out = lat_d;
		res.data_out  = dout_d;

		// end of sequence
		if (op_cur != OP_IDLE) begin
			step_d = s_next;
			if (s_next >= len) begin
				if (op_cur == OP_READ) begin
					res.fault_valid = 1'b1;
					res.fault_word  = 16'(acc_d);
				end else begin
					lat_d = 1'b1;
				end
				op_d   = OP_IDLE;
				step_d = '0;
			end
		end
	end

endmodule

`default_nettype wire
